FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types of the I2C master byte engine: the per-tick result record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_level;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: phase state, wait counter, bit counter and shift register.
// Advances by one tick per transfer and presents the resulting pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tick_i,
  input  wire logic [2:0]    command_i,
  input  wire logic [7:0]    write_data_i,
  input  wire logic          last_read_i,
  input  wire logic          sda_in_i,
  input  wire logic [15:0]   phase_ticks_i,
  input  wire logic [15:0]   setup_ticks_i,
  output i2cm_pkg::res_t     res_o
);

  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_A   = 5'd1;
  localparam logic [4:0] PH_START_B   = 5'd2;
  localparam logic [4:0] PH_STOP_A    = 5'd3;
  localparam logic [4:0] PH_W_LOW     = 5'd4;
  localparam logic [4:0] PH_W_SETUP   = 5'd5;
  localparam logic [4:0] PH_W_HIGH    = 5'd6;
  localparam logic [4:0] PH_W_ACKLOW  = 5'd7;
  localparam logic [4:0] PH_W_ACKHIGH = 5'd8;
  localparam logic [4:0] PH_R_LOW     = 5'd9;
  localparam logic [4:0] PH_R_HIGH    = 5'd10;
  localparam logic [4:0] PH_R_ACKLOW  = 5'd11;
  localparam logic [4:0] PH_R_ACKSET  = 5'd12;
  localparam logic [4:0] PH_R_ACKHIGH = 5'd13;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] wait_dec;
  logic [7:0]  shift_q, shift_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drive_q, drive_d;
  logic        nack_q, nack_d;
  logic        ack_q, ack_d;
  logic [7:0]  hold_q, hold_d;
  logic        done;
  logic [15:0] phase_load;
  logic [15:0] setup_load;

  assign phase_load = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;
  assign setup_load = (setup_ticks_i == 16'd0) ? 16'd1 : setup_ticks_i;
  assign wait_dec   = wait_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    wait_d    = wait_q;
    shift_d   = shift_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drive_d   = drive_q;
    nack_d    = nack_q;
    ack_d     = ack_q;
    hold_d    = hold_q;
    done      = 1'b0;
    if (phase_q == PH_IDLE) begin
      case (command_i)
        CMD_START: begin
          drive_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          wait_d  = phase_load; phase_d = PH_START_A;
        end
        CMD_STOP: begin
          drive_d = 1'b1; sda_d = 1'b0; scl_d = 1'b1;
          wait_d  = phase_load; phase_d = PH_STOP_A;
        end
        CMD_WRITE: begin
          drive_d = 1'b1; shift_d = write_data_i; bit_cnt_d = 4'd0; scl_d = 1'b0;
          wait_d  = phase_load; phase_d = PH_W_LOW;
        end
        CMD_READ: begin
          drive_d = 1'b0; shift_d = 8'd0; bit_cnt_d = 4'd0;
          nack_d  = last_read_i; scl_d = 1'b0;
          wait_d  = phase_load; phase_d = PH_R_LOW;
        end
        default: begin
        end
      endcase
    end else begin
      wait_d = wait_dec;
      if (wait_dec == 16'd0) begin
        case (phase_q)
          PH_START_A: begin
            sda_d = 1'b0; wait_d = phase_load; phase_d = PH_START_B;
          end
          PH_START_B: begin
            scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_STOP_A: begin
            sda_d = 1'b1; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_W_LOW: begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            wait_d  = setup_load; phase_d = PH_W_SETUP;
          end
          PH_W_SETUP: begin
            scl_d = 1'b1; wait_d = phase_load; phase_d = PH_W_HIGH;
          end
          PH_W_HIGH: begin
            bit_cnt_d = bit_cnt_q + 4'd1;
            scl_d     = 1'b0;
            wait_d    = phase_load;
            phase_d   = (bit_cnt_d < 4'd8) ? PH_W_LOW : PH_W_ACKLOW;
          end
          PH_W_ACKLOW: begin
            drive_d = 1'b0; scl_d = 1'b1;
            wait_d  = phase_load; phase_d = PH_W_ACKHIGH;
          end
          PH_W_ACKHIGH: begin
            ack_d = sda_in_i; scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_R_LOW: begin
            scl_d = 1'b1; wait_d = phase_load; phase_d = PH_R_HIGH;
          end
          PH_R_HIGH: begin
            shift_d   = {shift_q[6:0], sda_in_i};
            bit_cnt_d = bit_cnt_q + 4'd1;
            scl_d     = 1'b0;
            wait_d    = phase_load;
            phase_d   = (bit_cnt_d < 4'd8) ? PH_R_LOW : PH_R_ACKLOW;
          end
          PH_R_ACKLOW: begin
            drive_d = 1'b1; sda_d = nack_q;
            wait_d  = setup_load; phase_d = PH_R_ACKSET;
          end
          PH_R_ACKSET: begin
            scl_d = 1'b1; wait_d = phase_load; phase_d = PH_R_ACKHIGH;
          end
          PH_R_ACKHIGH: begin
            scl_d = 1'b0; hold_d = shift_q; phase_d = PH_IDLE; done = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 4'd0;
      wait_q    <= 16'd0;
      shift_q   <= 8'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drive_q   <= 1'b1;
      nack_q    <= 1'b0;
      ack_q     <= 1'b1;
      hold_q    <= 8'd0;
    end else if (tick_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      wait_q    <= wait_d;
      shift_q   <= shift_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drive_q   <= drive_d;
      nack_q    <= nack_d;
      ack_q     <= ack_d;
      hold_q    <= hold_d;
    end
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = drive_d ? sda_d : 1'b1;
  assign res_o.sda_drive = drive_d;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.read_data = hold_d;
  assign res_o.ack_level = ack_d;

endmodule

`default_nettype wire

FILE: hdl/i2cm_skid.sv
// ----------------------------------------------------------------------------
// i2cm_skid
// Two-entry output stage: result register plus skid register, so the input
// stall is a registered signal and a transfer can enter while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_skid (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  i2cm_pkg::res_t  res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output i2cm_pkg::res_t  res_o
);

  logic           out_vld_q, skid_vld_q;
  i2cm_pkg::res_t out_q, skid_q;
  logic           pop;

  assign pop = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || pop) begin
        out_vld_q <= skid_vld_q || push_i;
      end
      if (skid_vld_q && pop) begin
        skid_vld_q <= 1'b0;
      end else if (!skid_vld_q && push_i && out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skid_vld_q ? skid_q : res_i;
    end
    if (!skid_vld_q && push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

FILE: hdl/i2c_master_byte_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Bit-level I2C master. Each input transfer is one timing tick carrying the
// sampled SDA level and, while idle, an optional start, stop, write or read
// command; each tick yields one result transfer with the SCL/SDA levels,
// drive enable, busy, done, read byte and sampled ACK. One tick is taken
// every cycle unless in_stall_o is high; the sequencer step sits between
// the tick input and a two-entry registered output stage; in_stall_o
// rises only when both output entries are held by a stalled consumer.
// Wait lengths come from phase_ticks (index 0) and setup_ticks (index 1).
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  in_command_i,
  input  wire logic [7:0]  in_write_data_i,
  input  wire logic        in_last_read_i,
  input  wire logic        in_sda_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_scl_level_o,
  output logic             out_sda_level_o,
  output logic             out_sda_drive_o,
  output logic             out_busy_res_o,
  output logic             out_done_res_o,
  output logic [7:0]       out_read_data_o,
  output logic             out_ack_level_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] REG_SETUP_TICKS = 2'd1;

  logic [15:0]    phase_ticks_q;
  logic [15:0]    setup_ticks_q;
  logic           push;
  logic           full;
  i2cm_pkg::res_t step_res;
  i2cm_pkg::res_t out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd50;
      setup_ticks_q <= 16'd30;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        REG_SETUP_TICKS: setup_ticks_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (push),
    .command_i     (in_command_i),
    .write_data_i  (in_write_data_i),
    .last_read_i   (in_last_read_i),
    .sda_in_i      (in_sda_in_i),
    .phase_ticks_i (phase_ticks_q),
    .setup_ticks_i (setup_ticks_q),
    .res_o         (step_res)
  );

  i2cm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (step_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign out_scl_level_o = out_res.scl_level;
  assign out_sda_level_o = out_res.sda_level;
  assign out_sda_drive_o = out_res.sda_drive;
  assign out_busy_res_o  = out_res.busy_res;
  assign out_done_res_o  = out_res.done_res;
  assign out_read_data_o = out_res.read_data;
  assign out_ack_level_o = out_res.ack_level;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry held without an output entry");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_done_res_o && out_busy_res_o))
    else $error("done reported while busy");

  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_sda_drive_o) |-> out_sda_level_o)
    else $error("released SDA not reported high");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master byte engine. Every transfer on the
// input side is one timing tick; a cycle-accurate tracker of the sequencer
// predicts the per-tick pin levels, busy/done flags, read byte and ACK, and
// each output transfer is checked against the oldest prediction. Directed
// start/stop/write/read sequences, also under zero and long waits, and
// random command traffic under several wait settings are run, with
// random idle and stall bursts and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_RSV5  = 3'd5;
  localparam logic [2:0] CMD_RSV7  = 3'd7;

  localparam logic [1:0] REG_PHASE    = 2'd0;
  localparam logic [1:0] REG_SETUP    = 2'd1;
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_HOLD,
    ST_START_LOW,
    ST_STOP_HOLD,
    ST_WR_LOW,
    ST_WR_SETUP,
    ST_WR_HIGH,
    ST_WR_ACK_LOW,
    ST_WR_ACK_HIGH,
    ST_RD_LOW,
    ST_RD_HIGH,
    ST_RD_ACK_LOW,
    ST_RD_ACK_SETUP,
    ST_RD_ACK_HIGH
  } seq_state_e;

  class bus_level_tracker;
    logic [15:0]    phase_len;
    logic [15:0]    setup_len;
    seq_state_e     state;
    logic [3:0]     bits_done;
    logic [15:0]    wait_left;
    logic [7:0]     shifter;
    logic           scl_q;
    logic           sda_q;
    logic           drive_q;
    logic           nack_q;
    logic           ack_q;
    logic [7:0]     read_byte;
    i2cm_pkg::res_t expected_levels[$];
    int             mismatches;

    function new();
      phase_len  = 16'd50;
      setup_len  = 16'd30;
      state      = ST_IDLE;
      bits_done  = '0;
      wait_left  = '0;
      shifter    = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      drive_q    = 1'b1;
      nack_q     = 1'b0;
      ack_q      = 1'b1;
      read_byte  = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_PHASE) begin
        phase_len = val;
      end else if (idx == REG_SETUP) begin
        setup_len = val;
      end
    endfunction

    function bit busy();
      return state != ST_IDLE;
    endfunction

    function void arm_wait(logic [15:0] len, seq_state_e nxt);
      wait_left = (len == '0) ? 16'd1 : len;
      state     = nxt;
    endfunction

    function void note_tick(logic [2:0] cmd, logic [7:0] wdata, logic last, logic sda);
      i2cm_pkg::res_t lv;
      logic fin;
      fin = 1'b0;
      if (state == ST_IDLE) begin
        case (cmd)
          CMD_START: begin
            drive_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
            arm_wait(phase_len, ST_START_HOLD);
          end
          CMD_STOP: begin
            drive_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
            arm_wait(phase_len, ST_STOP_HOLD);
          end
          CMD_WRITE: begin
            drive_q = 1'b1; shifter = wdata; bits_done = '0; scl_q = 1'b0;
            arm_wait(phase_len, ST_WR_LOW);
          end
          CMD_READ: begin
            drive_q = 1'b0; shifter = '0; bits_done = '0; nack_q = last; scl_q = 1'b0;
            arm_wait(phase_len, ST_RD_LOW);
          end
          default: ;
        endcase
      end else begin
        wait_left = wait_left - 16'd1;
        if (wait_left == '0) begin
          case (state)
            ST_START_HOLD: begin
              sda_q = 1'b0;
              arm_wait(phase_len, ST_START_LOW);
            end
            ST_START_LOW: begin
              scl_q = 1'b0; state = ST_IDLE; fin = 1'b1;
            end
            ST_STOP_HOLD: begin
              sda_q = 1'b1; state = ST_IDLE; fin = 1'b1;
            end
            ST_WR_LOW: begin
              sda_q   = shifter[7];
              shifter = shifter << 1;
              arm_wait(setup_len, ST_WR_SETUP);
            end
            ST_WR_SETUP: begin
              scl_q = 1'b1;
              arm_wait(phase_len, ST_WR_HIGH);
            end
            ST_WR_HIGH: begin
              bits_done = bits_done + 4'd1;
              scl_q     = 1'b0;
              arm_wait(phase_len, (bits_done < 4'd8) ? ST_WR_LOW : ST_WR_ACK_LOW);
            end
            ST_WR_ACK_LOW: begin
              drive_q = 1'b0; scl_q = 1'b1;
              arm_wait(phase_len, ST_WR_ACK_HIGH);
            end
            ST_WR_ACK_HIGH: begin
              ack_q = sda; scl_q = 1'b0; state = ST_IDLE; fin = 1'b1;
            end
            ST_RD_LOW: begin
              scl_q = 1'b1;
              arm_wait(phase_len, ST_RD_HIGH);
            end
            ST_RD_HIGH: begin
              shifter   = {shifter[6:0], sda};
              bits_done = bits_done + 4'd1;
              scl_q     = 1'b0;
              arm_wait(phase_len, (bits_done < 4'd8) ? ST_RD_LOW : ST_RD_ACK_LOW);
            end
            ST_RD_ACK_LOW: begin
              drive_q = 1'b1; sda_q = nack_q;
              arm_wait(setup_len, ST_RD_ACK_SETUP);
            end
            ST_RD_ACK_SETUP: begin
              scl_q = 1'b1;
              arm_wait(phase_len, ST_RD_ACK_HIGH);
            end
            ST_RD_ACK_HIGH: begin
              scl_q = 1'b0; read_byte = shifter; state = ST_IDLE; fin = 1'b1;
            end
            default: state = ST_IDLE;
          endcase
        end
      end
      lv.scl_level = scl_q;
      lv.sda_level = drive_q ? sda_q : 1'b1;
      lv.sda_drive = drive_q;
      lv.busy_res  = (state != ST_IDLE);
      lv.done_res  = fin;
      lv.read_data = read_byte;
      lv.ack_level = ack_q;
      expected_levels.push_back(lv);
    endfunction

    function string show(i2cm_pkg::res_t r);
      return $sformatf("scl=%b sda=%b drive=%b busy=%b done=%b rdata=%h ack=%b",
                       r.scl_level, r.sda_level, r.sda_drive, r.busy_res,
                       r.done_res, r.read_data, r.ack_level);
    endfunction

    function void check_levels(i2cm_pkg::res_t got);
      i2cm_pkg::res_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %s", show(got));
        return;
      end
      want = expected_levels.pop_front();
      if (want.scl_level !== got.scl_level || want.sda_level !== got.sda_level ||
          want.sda_drive !== got.sda_drive || want.busy_res !== got.busy_res ||
          want.done_res !== got.done_res || want.read_data !== got.read_data ||
          want.ack_level !== got.ack_level) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [2:0]  in_command_i    = CMD_TICK;
  logic [7:0]  in_write_data_i = '0;
  logic        in_last_read_i  = 1'b0;
  logic        in_sda_in_i     = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic        out_scl_level_o;
  logic        out_sda_level_o;
  logic        out_sda_drive_o;
  logic        out_busy_res_o;
  logic        out_done_res_o;
  logic [7:0]  out_read_data_o;
  logic        out_ack_level_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = REG_PHASE;
  logic [15:0] cfg_data_i      = '0;

  bus_level_tracker levels = new();
  int               src_idle_pct  = 0;
  int               sink_idle_pct = 0;
  bit               hold_off_req  = 1'b0;
  int unsigned      cycle_count   = 0;

  i2c_master_byte_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_command_i   (in_command_i),
    .in_write_data_i(in_write_data_i),
    .in_last_read_i (in_last_read_i),
    .in_sda_in_i    (in_sda_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_scl_level_o(out_scl_level_o),
    .out_sda_level_o(out_sda_level_o),
    .out_sda_drive_o(out_sda_drive_o),
    .out_busy_res_o (out_busy_res_o),
    .out_done_res_o (out_done_res_o),
    .out_read_data_o(out_read_data_o),
    .out_ack_level_o(out_ack_level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      levels.check_levels(i2cm_pkg::res_t'{scl_level: out_scl_level_o,
                                           sda_level: out_sda_level_o,
                                           sda_drive: out_sda_drive_o,
                                           busy_res: out_busy_res_o,
                                           done_res: out_done_res_o,
                                           read_data: out_read_data_o,
                                           ack_level: out_ack_level_o});
    end
  end

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_tick(logic [2:0] cmd, logic [7:0] wdata, logic last, logic sda);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_command_i    <= cmd;
    in_write_data_i <= wdata;
    in_last_read_i  <= last;
    in_sda_in_i     <= sda;
    do @(posedge clk_i); while (in_stall_o);
    levels.note_tick(cmd, wdata, last, sda);
  endtask

  // Feed ticks until the sequencer is idle; SDA follows the byte pattern, then ack.
  task automatic finish_sequence(logic [7:0] pattern, logic ack);
    logic       sda;
    logic [2:0] cmd;
    while (levels.busy()) begin
      sda = (levels.bits_done < 4'd8) ? pattern[3'd7 - levels.bits_done[2:0]] : ack;
      cmd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_TICK;
      push_tick(cmd, 8'($urandom), 1'($urandom), sda);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (levels.expected_levels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [15:0] ph, logic [15:0] su, bit spare);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PHASE;
    cfg_data_i  <= ph;
    do @(posedge clk_i); while (!cfg_ready_o);
    levels.set_register(REG_PHASE, ph);
    cfg_index_i <= REG_SETUP;
    cfg_data_i  <= su;
    do @(posedge clk_i); while (!cfg_ready_o);
    levels.set_register(REG_SETUP, su);
    if (spare) begin
      cfg_index_i <= REG_SPARE_LO;
      cfg_data_i  <= 16'($urandom);
      do @(posedge clk_i); while (!cfg_ready_o);
      levels.set_register(REG_SPARE_LO, cfg_data_i);
      cfg_index_i <= REG_SPARE_HI;
      cfg_data_i  <= 16'($urandom);
      do @(posedge clk_i); while (!cfg_ready_o);
      levels.set_register(REG_SPARE_HI, cfg_data_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_traffic(int count);
    logic [2:0] cmd;
    int         pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (levels.busy()) begin
        cmd = (pick < 25) ? 3'($urandom_range(0, 7)) : CMD_TICK;
      end else if (pick < 70) begin
        cmd = 3'($urandom_range(CMD_START, CMD_READ));
      end else if (pick < 85) begin
        cmd = CMD_TICK;
      end else begin
        cmd = 3'($urandom_range(CMD_RSV5, CMD_RSV7));
      end
      push_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    finish_sequence(8'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset wait lengths
    push_tick(CMD_START, 8'h00, 1'b0, 1'b1);
    finish_sequence(8'h00, 1'b1);

    program_regs(16'd1, 16'd1, 1'b0);
    push_tick(CMD_WRITE, 8'hFF, 1'b0, 1'b1);
    push_tick(CMD_READ, 8'h00, 1'b1, 1'b0);
    finish_sequence(8'h00, 1'b0);
    push_tick(CMD_WRITE, 8'h00, 1'b1, 1'b0);
    finish_sequence(8'hFF, 1'b1);
    push_tick(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
    finish_sequence(8'h00, 1'b0);
    push_tick(CMD_READ, 8'h00, 1'b0, 1'b1);
    finish_sequence(8'h5A, 1'b1);
    push_tick(CMD_READ, 8'hFF, 1'b1, 1'b0);
    finish_sequence(8'hFF, 1'b1);
    push_tick(CMD_READ, 8'h00, 1'b0, 1'b0);
    finish_sequence(8'h00, 1'b0);
    push_tick(CMD_STOP, 8'h00, 1'b0, 1'b0);
    finish_sequence(8'h00, 1'b0);
    push_tick(CMD_RSV5, 8'hFF, 1'b1, 1'b1);
    push_tick(CMD_RSV5 + 3'd1, 8'h00, 1'b0, 1'b0);
    push_tick(CMD_RSV7, 8'hFF, 1'b1, 1'b1);

    // zero waits behave as one tick; spare indexes are ignored
    program_regs(16'd0, 16'd0, 1'b1);
    push_tick(CMD_START, 8'h00, 1'b0, 1'b1);
    finish_sequence(8'h00, 1'b1);
    push_tick(CMD_WRITE, 8'h81, 1'b0, 1'b1);
    finish_sequence(8'h00, 1'b0);
    push_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
    finish_sequence(8'h81, 1'b0);
    push_tick(CMD_STOP, 8'h00, 1'b0, 1'b0);
    finish_sequence(8'h00, 1'b0);

    program_regs(16'd1, 16'd1, 1'b0);
    src_idle_pct = 15; sink_idle_pct = 15;
    run_traffic(250);

    program_regs(16'd2, 16'd1, 1'b0);
    src_idle_pct = 30; sink_idle_pct = 30;
    run_traffic(250);

    // hold the output side off while ticks keep coming
    program_regs(16'd1, 16'd3, 1'b0);
    src_idle_pct = 0; sink_idle_pct = 0;
    hold_off_req = 1'b1;
    run_traffic(250);

    program_regs(16'd3, 16'd2, 1'b0);
    src_idle_pct = 10; sink_idle_pct = 25;
    run_traffic(250);

    program_regs(16'd4, 16'd1, 1'b0);
    src_idle_pct = 25; sink_idle_pct = 10;
    run_traffic(250);

    // long waits
    src_idle_pct = 3; sink_idle_pct = 3;
    program_regs(16'd60, 16'd1, 1'b0);
    push_tick(CMD_STOP, 8'h00, 1'b0, 1'b0);
    finish_sequence(8'($urandom), 1'b0);
    program_regs(16'd1, 16'd45, 1'b0);
    push_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
    finish_sequence(8'($urandom), 1'b1);

    program_regs(16'd2, 16'd2, 1'b0);
    src_idle_pct = 0; sink_idle_pct = 0;
    run_traffic(250);

    settle();
    if (levels.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/i2cm_pkg.sv
hdl/i2cm_seq.sv
hdl/i2cm_skid.sv
hdl/i2c_master_byte_engine_core.sv
verif/tb_top.sv
